// File: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Sorted pair-sum search: shared package
// Widths, default depth and the command and status words that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default number of stored elements.
  localparam int unsigned DefaultDepth = 256;

  // Width of one element and of the target sum.
  localparam int unsigned ValueW = 32;

  // Width of the reported index fields.
  localparam int unsigned IndexW = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // store an accepted word, or note that it was dropped
    logic start;    // set up the two pointers for a new search
    logic read;     // fetch the elements at both pointers
    logic inc_lo;   // move the low pointer up
    logic dec_hi;   // move the high pointer down
    logic finish;   // capture the result and clear the list
    logic found;    // with finish: a matching pair sits at the pointers
  } sps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_lt;   // low pointer is below the high pointer
    logic sum_eq;   // fetched pair sums to the target
    logic sum_gt;   // fetched pair sums above the target
  } sps_status_t;

endpackage

// File: rtl/sps_datapath.sv
// ----------------------------------------------------------------------------
// Sorted pair-sum search: datapath
// Element memory, fill count, overflow flag, the two search pointers, the
// sum comparator and the result register.
// ----------------------------------------------------------------------------
module sps_datapath
  import sps_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sps_cmd_t                 cmd_i,
  output sps_status_t              status_o,
  input  logic signed [ValueW-1:0] element_value_i,
  input  logic                     cfg_we_i,
  input  logic signed [ValueW-1:0] cfg_target_sum_i,
  output logic                     pair_found_o,
  output logic        [IndexW-1:0] low_index_o,
  output logic        [IndexW-1:0] high_index_o,
  output logic                     list_overflow_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic        [ValueW-1:0] mem_q [DEPTH];
  logic        [ValueW-1:0] rd_lo_q, rd_hi_q;
  logic        [CW-1:0]     count_q;
  logic                     overflow_q;
  logic        [AW-1:0]     lo_q, hi_q;
  logic signed [ValueW-1:0] target_q;
  logic                     found_q, res_ovf_q;
  logic        [IndexW-1:0] res_lo_q, res_hi_q;
  logic                     full;
  logic signed [ValueW:0]   pair_sum, want_sum;

  assign full = (count_q == CW'(DEPTH));

  // Element memory with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[AW-1:0]] <= element_value_i;
    end
    if (cmd_i.read) begin
      rd_lo_q <= mem_q[lo_q];
      rd_hi_q <= mem_q[hi_q];
    end
  end

  // Exact 33-bit sum of the fetched pair against the sign-extended target.
  assign pair_sum = $signed({rd_lo_q[ValueW-1], rd_lo_q})
                  + $signed({rd_hi_q[ValueW-1], rd_hi_q});
  assign want_sum = $signed({target_q[ValueW-1], target_q});

  assign status_o.ptr_lt = (lo_q < hi_q);
  assign status_o.sum_eq = (pair_sum == want_sum);
  assign status_o.sum_gt = (pair_sum > want_sum);

  // Fill count and overflow flag; both clear once the result is captured.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (cmd_i.finish) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        overflow_q <= 1'b1;
      end else begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // Search pointers. The high pointer starts at the last stored element.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lo_q <= '0;
      hi_q <= full ? AW'(DEPTH - 1) : count_q[AW-1:0];
    end else begin
      if (cmd_i.inc_lo) begin
        lo_q <= lo_q + AW'(1);
      end
      if (cmd_i.dec_hi) begin
        hi_q <= hi_q - AW'(1);
      end
    end
  end

  // Target sum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_target_sum_i;
    end
  end

  // Result register, held until the next search ends.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q   <= cmd_i.found;
      res_lo_q  <= cmd_i.found ? IndexW'(lo_q) : '0;
      res_hi_q  <= cmd_i.found ? IndexW'(hi_q) : '0;
      res_ovf_q <= overflow_q;
    end
  end

  assign pair_found_o    = found_q;
  assign low_index_o     = res_lo_q;
  assign high_index_o    = res_hi_q;
  assign list_overflow_o = res_ovf_q;

`ifndef ASSERT_OFF
  // The fill count never passes the depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  // A pointer step only follows a fetch made with the pointers still apart.
  a_step_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.inc_lo || cmd_i.dec_hi) |-> (lo_q < hi_q))
    else $error("pointer step with crossed pointers");

  // Capturing a result leaves an empty list behind.
  a_finish_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (count_q == '0) && !overflow_q)
    else $error("list not cleared after result");
`endif

endmodule

// File: rtl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted pair-sum search: controller
// Sequences loading, the two-pointer walk and the hand-off of the result to
// the output register.
// ----------------------------------------------------------------------------
module sps_ctrl
  import sps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  sps_status_t status_i,
  output sps_cmd_t    cmd_o
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  // The last word of a list waits until the previous result has been taken.
  assign in_ready_o = (state_q == S_LOAD) && !(out_valid_q && last_element_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          if (last_element_i) begin
            cmd_o.start = 1'b1;
            state_d     = S_READ;
          end
        end
      end
      S_READ: begin
        if (status_i.ptr_lt) begin
          cmd_o.read = 1'b1;
          state_d    = S_CMP;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_CMP: begin
        if (status_i.sum_eq) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = 1'b1;
          state_d      = S_LOAD;
        end else begin
          cmd_o.dec_hi = status_i.sum_gt;
          cmd_o.inc_lo = !status_i.sum_gt;
          state_d      = S_READ;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Output valid: set when a result is captured, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // A search never ends while the previous result is still pending.
  a_finish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !out_valid_q)
    else $error("result captured over a pending result");

  // A search starts only on an accepted last word.
  a_start_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> (in_valid_i && in_ready_o && last_element_i))
    else $error("search started without last word");

  // No word is taken while a search runs.
  a_no_load_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_CMP) |-> !in_ready_o)
    else $error("input ready during search");
`endif

endmodule

// File: rtl/sorted_pair_sum_search.sv
// ----------------------------------------------------------------------------
// Sorted pair-sum search: top level
// Loads an ascending list of signed words, then walks two pointers inward
// to find a pair whose exact sum equals the target.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   element_value_i, last_element_i
//   out      output     out_valid_o/out_ready_i pair_found_o, low_index_o,
//                                               high_index_o, list_overflow_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_target_sum_i
//
// Loading takes one word per cycle while no search runs. Each pointer step
// of the search is a registered read of both memory ports, then the sum
// compare, until the pointers meet or a matching pair is found.
// The result sits in an output register; words of the next list are taken
// while it waits, but the next last word stalls until the result is taken.
// Reset clears the controller, fill count, overflow flag and target; the
// element memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_pair_sum_search
  import sps_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] element_value_i,
  input  logic                     last_element_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     pair_found_o,
  output logic        [IndexW-1:0] low_index_o,
  output logic        [IndexW-1:0] high_index_o,
  output logic                     list_overflow_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [ValueW-1:0] cfg_target_sum_i
);

  sps_cmd_t    cmd;
  sps_status_t status;

  // The target register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  sps_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  sps_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .element_value_i  (element_value_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_target_sum_i (cfg_target_sum_i),
    .pair_found_o     (pair_found_o),
    .low_index_o      (low_index_o),
    .high_index_o     (high_index_o),
    .list_overflow_o  (list_overflow_o)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted pair-sum search: testbench
// Feeds lists of signed words through the input channel, writes the target
// between lists, and checks every search result against a predictor that
// keeps its own copy of the stored list, the overflow flag and the target.
// ----------------------------------------------------------------------------
module testbench;
  import sps_pkg::*;

  localparam int unsigned Depth = DefaultDepth;
  // The limit covers the longest search; the receiver may stall on top.
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned TailCycles = 2 * Depth + 100;
  localparam int unsigned MaxReports = 10;

  typedef logic signed [ValueW-1:0] word_t;
  typedef word_t word_q_t[$];

  localparam word_t WordMin = {1'b1, {(ValueW-1){1'b0}}};
  localparam word_t WordMax = {1'b0, {(ValueW-1){1'b1}}};

  typedef enum {SpreadFull, SpreadNearHalf, SpreadCorner} spread_t;
  typedef enum {ShapePlanted, ShapePlain, ShapeUnsorted, ShapeCorner} list_shape_t;

  typedef struct {
    word_t value;
    logic  last;
    bit    drain_first;
  } element_item_t;

  typedef struct {
    logic              found;
    logic [IndexW-1:0] lo_idx;
    logic [IndexW-1:0] hi_idx;
    logic              ovf;
  } pair_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  word_t             element_value_i = '0;
  logic              last_element_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              pair_found_o;
  logic [IndexW-1:0] low_index_o;
  logic [IndexW-1:0] high_index_o;
  logic              list_overflow_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  word_t             cfg_target_sum_i = '0;

  // Words waiting to be sent, and search results waiting to arrive.
  element_item_t element_feed_q[$];
  pair_result_t  pair_expect_q[$];
  word_q_t       draft_words;

  // Predictor state.
  word_t       stored_words [Depth];
  int unsigned stored_count = 0;
  bit          dropped_any = 1'b0;
  word_t       target_model = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_taken = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  sorted_pair_sum_search #(
    .DEPTH(Depth)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .last_element_i  (last_element_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pair_found_o    (pair_found_o),
    .low_index_o     (low_index_o),
    .high_index_o    (high_index_o),
    .list_overflow_o (list_overflow_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_target_sum_i(cfg_target_sum_i)
  );

  // Clock generation.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Two-pointer walk over the stored list with the exact 33-bit sum.
  function automatic pair_result_t search_pair();
    pair_result_t r;
    int unsigned  lo;
    int unsigned  hi;
    longint       want;
    longint       s;
    r.found = 1'b0;
    r.lo_idx = '0;
    r.hi_idx = '0;
    r.ovf = dropped_any;
    want = longint'(target_model);
    lo = 0;
    hi = stored_count - 1;
    while (lo < hi && !r.found) begin
      s = longint'(stored_words[lo]) + longint'(stored_words[hi]);
      if (s == want) begin
        r.found = 1'b1;
        r.lo_idx = lo[IndexW-1:0];
        r.hi_idx = hi[IndexW-1:0];
      end else if (s > want) begin
        hi--;
      end else begin
        lo++;
      end
    end
    return r;
  endfunction

  // Store one accepted word; a last word closes the list and yields a result.
  task automatic absorb_element(input word_t value, input logic last);
    if (stored_count < Depth) begin
      stored_words[stored_count] = value;
      stored_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (last) begin
      pair_expect_q.push_back(search_pair());
      stored_count = 0;
      dropped_any = 1'b0;
    end
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_result();
    pair_result_t want;
    if (pair_expect_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
        $display("%0t: result with nothing pending: found=%0d lo=%0d hi=%0d ovf=%0d",
                 $realtime, pair_found_o, low_index_o, high_index_o, list_overflow_o);
      end
    end else begin
      want = pair_expect_q.pop_front();
      if (pair_found_o !== want.found || low_index_o !== want.lo_idx ||
          high_index_o !== want.hi_idx || list_overflow_o !== want.ovf) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: mismatch: expected found=%0d lo=%0d hi=%0d ovf=%0d, got found=%0d lo=%0d hi=%0d ovf=%0d",
                   $realtime, want.found, want.lo_idx, want.hi_idx, want.ovf,
                   pair_found_o, low_index_o, high_index_o, list_overflow_o);
        end
      end
    end
  endtask

  // Monitor: observe every handshake at the rising edge and update the model.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) target_model = cfg_target_sum_i;
      if (in_valid_i && in_ready_o) absorb_element(element_value_i, last_element_i);
      if (out_valid_o && out_ready_i) check_result();
    end
  end

  // Driver: present the next word at the falling edge once the slot is free.
  always @(negedge clk_i) begin
    element_item_t next_word;
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (element_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          !(element_feed_q[0].drain_first && pair_expect_q.size() != 0)) begin
        next_word = element_feed_q.pop_front();
        in_valid_i <= 1'b1;
        element_value_i <= next_word.value;
        last_element_i <= next_word.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write the target register through its own channel.
  task automatic write_target(input word_t value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_target_sum_i <= value;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Block until every word is sent and every result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    while (element_feed_q.size() != 0 || in_valid_i || pair_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic stage(input word_t value);
    draft_words.push_back(value);
  endtask

  // Turn the staged words into one list; the final word carries the last flag.
  task automatic close_list(input bit drain);
    element_item_t it;
    foreach (draft_words[i]) begin
      it.value = draft_words[i];
      it.last = (i == draft_words.size() - 1);
      it.drain_first = drain && (i == 0);
      element_feed_q.push_back(it);
    end
    draft_words.delete();
  endtask

  function automatic word_t pick_word(input word_t goal, input spread_t spread);
    longint      c;
    int unsigned k;
    case (spread)
      SpreadFull: return word_t'($urandom);
      SpreadNearHalf: begin
        // Values near half the target make sums land close to it.
        c = (longint'(goal) >>> 1) + longint'($urandom_range(0, 64)) - 64'sd32;
        if (c < longint'(WordMin)) c = longint'(WordMin);
        if (c > longint'(WordMax)) c = longint'(WordMax);
        return word_t'(c);
      end
      default: begin
        k = $urandom_range(0, 4);
        case (k)
          0: return WordMin;
          1: return WordMax;
          2: return word_t'(0);
          3: return word_t'(-1);
          default: return word_t'(1);
        endcase
      end
    endcase
  endfunction

  // Build one random list of n words aimed at the given target.
  task automatic random_list(input word_t goal, input int unsigned n, input bit drain);
    word_q_t      vals;
    list_shape_t  shape;
    spread_t      spread;
    int unsigned  roll;
    word_t        a;
    longint       b;
    int unsigned  pa;
    int unsigned  pb;
    word_t        tmp;
    int           j;
    roll = $urandom_range(0, 9);
    if (roll < 6) shape = ShapePlanted;
    else if (roll < 8) shape = ShapePlain;
    else if (roll < 9) shape = ShapeUnsorted;
    else shape = ShapeCorner;
    for (int i = 0; i < n; i++) begin
      if (shape == ShapeCorner) spread = SpreadCorner;
      else if ($urandom_range(0, 1) == 1) spread = SpreadNearHalf;
      else spread = SpreadFull;
      vals.push_back(pick_word(goal, spread));
    end
    // Plant a pair that sums exactly to the target.
    if (shape == ShapePlanted && n >= 2) begin
      a = pick_word(goal, SpreadNearHalf);
      b = longint'(goal) - longint'(a);
      if (b >= longint'(WordMin) && b <= longint'(WordMax)) begin
        pa = $urandom_range(0, n - 1);
        do pb = $urandom_range(0, n - 1); while (pb == pa);
        vals[pa] = a;
        vals[pb] = word_t'(b);
      end
    end
    // Ascending order, except for the deliberately unsorted lists.
    if (shape != ShapeUnsorted) begin
      for (int i = 1; i < vals.size(); i++) begin
        tmp = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > tmp) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = tmp;
      end
    end
    draft_words = vals;
    close_list(drain);
  endtask

  // Stimulus and end of run.
  initial begin
    word_t       goal;
    int unsigned budget;
    int unsigned n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Target at its reset value of zero.
    stage(word_t'(5));
    close_list(1'b1);                  // single word, pointers start equal
    stage(word_t'(-3));
    stage(word_t'(3));
    close_list(1'b0);
    stage(WordMin);
    stage(word_t'(-5));
    stage(word_t'(0));
    stage(word_t'(7));
    stage(WordMax);
    close_list(1'b0);
    stage(WordMax);
    stage(WordMax);
    close_list(1'b0);                  // sum needs the 33rd bit
    stage(WordMin);
    stage(WordMin);
    close_list(1'b0);                  // wraps to zero in 32 bits only
    stage(word_t'(9));
    stage(word_t'(-4));
    stage(word_t'(1));
    stage(word_t'(-9));
    close_list(1'b0);                  // unsorted list

    wait_drained();
    write_target(word_t'(-2));
    stage(word_t'(-1));
    stage(word_t'(-1));
    stage(WordMax);
    stage(WordMax);
    close_list(1'b0);
    wait_drained();
    write_target(WordMax);
    stage(word_t'(0));
    stage(WordMax);
    close_list(1'b0);
    wait_drained();
    write_target(WordMin);
    stage(WordMin);
    stage(word_t'(0));
    stage(word_t'(1));
    close_list(1'b0);

    // Random phases, each with its own target and idling pattern.
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      if (phase == 5) goal = word_t'(int'($urandom_range(0, 200)) - 100);
      else goal = word_t'($urandom);
      write_target(goal);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct = 9;
        end
      endcase
      // Overflow drops every word past Depth; a list of exactly Depth fills the store.
      if (phase == 2) random_list(goal, Depth + 1, 1'b1);
      if (phase == 4) random_list(goal, Depth, 1'b0);
      if (phase == 6) random_list(goal, Depth + $urandom_range(2, 40), 1'b0);
      budget = 0;
      while (budget < 60) begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(17, 48);
        else n = $urandom_range(1, 16);
        random_list(goal, n, $urandom_range(0, 7) == 0);
        budget += n;
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (pair_expect_q.size() != 0) begin
      $display("%0d expected results never arrived", pair_expect_q.size());
    end
    if (mismatch_count == 0 && pair_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
